@@ rtl/fifo_page_replacement_counter_assert.svh @@
// Assertion macros used by the FIFO page replacement counter top level
`ifndef FIFO_PAGE_REPLACEMENT_COUNTER_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_COUNTER_ASSERT_SVH

// same-cycle implication
`define FPRC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("assertion failed");

// next-cycle implication
`define FPRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/fprc_pkg.sv @@
// Package: types and constants of the FIFO page replacement counter
package fprc_pkg;

   localparam int FRAMES_DEFAULT    = 16;
   localparam int PAGE_BITS_DEFAULT = 16;

   localparam int CSR_W    = 5;
   localparam int PAGE_W   = 16;
   localparam int FAULT_W  = 24;
   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
   localparam logic [CSR_W-1:0]   FRAMES_RESET = 5'd4;

   localparam logic REQ_REFERENCE = 1'b0;
   localparam logic REQ_END_RUN   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                req_type;
      logic [PAGE_W-1:0]   page_number;
   } req_word_type;

   typedef struct packed {
      logic                was_fault;
      logic [FAULT_W-1:0]  fault_count;
      logic                anomaly_seen;
      logic                run_done;
   } rsp_word_type;

   // lookup token traveling down the cell chain
   typedef struct packed {
      logic valid;
      logic hit;
   } search_type;

   // broadcast frame control
   typedef struct packed {
      logic write_en;
      logic clear;
   } cell_ctl_type;

endpackage

@@ rtl/fprc_stream_if.sv @@
// Interface: valid/ready stream channel carrying one word
interface fprc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fifo_page_replacement_counter.sv @@
// Top level: FIFO page replacement counter with a chain of frame cells
//
//   port       dir  word           handshake
//   req_chan   in   req_word_type  valid/ready
//   rsp_chan   out  rsp_word_type  valid/ready
//   csr_*      in   frames_in_use  write enable, no wait
//
// A page reference is taken in ST_IDLE; the lookup token then walks the FRAMES
// cells one per cycle, and the result commits in ST_FINISH once the output is free.
// An end-of-run word skips the search and commits. One word is in flight at a time.
// Reset clears valid bits and counters at once; no sweep.
// A stalled result holds the next commit; the next word is still taken while it waits.
module fifo_page_replacement_counter #(
   parameter int FRAMES    = fprc_pkg::FRAMES_DEFAULT,
   parameter int PAGE_BITS = fprc_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   fprc_stream_if.sink                  req_chan,
   fprc_stream_if.source                rsp_chan,
   input  logic                         csr_write_en,
   input  logic [fprc_pkg::CSR_W-1:0]   csr_write_data
);

   localparam int CNT_W  = $clog2(FRAMES + 1);
   localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CMP_W  = (CNT_W > fprc_pkg::CSR_W) ? CNT_W : fprc_pkg::CSR_W;
   localparam int FW     = fprc_pkg::FAULT_W;

   `include "fifo_page_replacement_counter_assert.svh"

   fprc_pkg::state_type     state_ff, state_in;
   logic [fprc_pkg::CSR_W-1:0] frames_ff;
   logic [SLOT_W-1:0]       next_slot_ff, next_slot_in;
   logic [FW-1:0]           run_faults_ff, run_faults_in;
   logic [FW-1:0]           rec_faults_ff, rec_faults_in;
   logic [CNT_W-1:0]        rec_frames_ff, rec_frames_in;
   logic                    have_rec_ff, have_rec_in;
   logic                    anomaly_ff, anomaly_in;
   logic                    end_ff;
   logic                    hit_ff;
   logic [PAGE_BITS-1:0]    page_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   fprc_pkg::rsp_word_type  rsp_word_ff, rsp_word_in;

   logic [CMP_W-1:0]        frames_ext;
   logic [CNT_W-1:0]        frame_cnt;
   logic [PAGE_BITS-1:0]    req_page;
   logic                    launch, commit, fault;
   logic [SLOT_W-1:0]       slot;
   logic [FW-1:0]           faults_upd;
   fprc_pkg::cell_ctl_type  ctl;

   fprc_pkg::search_type    srch [FRAMES+1];
   logic [PAGE_BITS-1:0]    tok_page [FRAMES+1];
   logic [FRAMES-1:0]       tok_vec;

   // effective frame count
   always_comb begin
      frames_ext = CMP_W'(frames_ff);
      if (frames_ext == '0) begin
         frame_cnt = CNT_W'(1);
      end else if (frames_ext > CMP_W'(FRAMES)) begin
         frame_cnt = CNT_W'(FRAMES);
      end else begin
         frame_cnt = CNT_W'(frames_ext);
      end
   end

   assign req_page = PAGE_BITS'(req_chan.data.page_number);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fprc_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.data.req_type == fprc_pkg::REQ_END_RUN) begin
                  state_in = fprc_pkg::ST_FINISH;
               end else begin
                  state_in = fprc_pkg::ST_SEARCH;
               end
            end
         end
         fprc_pkg::ST_SEARCH: begin
            if (srch[FRAMES].valid) begin
               state_in = fprc_pkg::ST_FINISH;
            end
         end
         fprc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = fprc_pkg::ST_IDLE;
            end
         end
         default: state_in = fprc_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = 1'b0;
      launch         = 1'b0;
      commit         = 1'b0;
      case (state_ff)
         fprc_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            launch = req_chan.valid && (req_chan.data.req_type == fprc_pkg::REQ_REFERENCE);
         end
         fprc_pkg::ST_FINISH: begin
            commit = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // commit datapath
   always_comb begin
      fault = !end_ff && !hit_ff;
      slot  = ((CNT_W'(next_slot_ff) < frame_cnt)) ? next_slot_ff : '0;
      faults_upd = (fault && (run_faults_ff != fprc_pkg::FAULT_MAX)) ?
                   run_faults_ff + FW'(1) : run_faults_ff;

      next_slot_in  = next_slot_ff;
      run_faults_in = run_faults_ff;
      rec_faults_in = rec_faults_ff;
      rec_frames_in = rec_frames_ff;
      have_rec_in   = have_rec_ff;
      anomaly_in    = anomaly_ff;

      if (end_ff) begin
         run_faults_in = '0;
         next_slot_in  = '0;
         if (!have_rec_ff) begin
            have_rec_in   = 1'b1;
            rec_faults_in = run_faults_ff;
            rec_frames_in = frame_cnt;
         end else if ((run_faults_ff > rec_faults_ff) && (frame_cnt > rec_frames_ff)) begin
            rec_faults_in = run_faults_ff;
            rec_frames_in = frame_cnt;
            anomaly_in    = 1'b1;
         end
      end else if (fault) begin
         run_faults_in = faults_upd;
         next_slot_in  = ((CNT_W'(slot) + CNT_W'(1)) < frame_cnt) ? slot + SLOT_W'(1) : '0;
      end

      rsp_word_in.was_fault    = fault;
      rsp_word_in.fault_count  = end_ff ? run_faults_ff : faults_upd;
      rsp_word_in.anomaly_seen = anomaly_in;
      rsp_word_in.run_done     = end_ff;

      ctl.write_en = commit && fault;
      ctl.clear    = commit && end_ff;

      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fprc_pkg::ST_IDLE;
         frames_ff     <= fprc_pkg::FRAMES_RESET;
         next_slot_ff  <= '0;
         run_faults_ff <= '0;
         rec_faults_ff <= '0;
         rec_frames_ff <= '0;
         have_rec_ff   <= 1'b0;
         anomaly_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            frames_ff <= csr_write_data;
         end
         if (commit) begin
            next_slot_ff  <= next_slot_in;
            run_faults_ff <= run_faults_in;
            rec_faults_ff <= rec_faults_in;
            rec_frames_ff <= rec_frames_in;
            have_rec_ff   <= have_rec_in;
            anomaly_ff    <= anomaly_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         end_ff  <= req_chan.data.req_type;
         page_ff <= req_page;
         hit_ff  <= 1'b0;
      end else if ((state_ff == fprc_pkg::ST_SEARCH) && srch[FRAMES].valid) begin
         hit_ff <= srch[FRAMES].hit;
      end
      if (commit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   // lookup chain
   assign srch[0].valid = launch;
   assign srch[0].hit   = 1'b0;
   assign tok_page[0]   = req_page;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      fprc_cell #(
         .INDEX     (i),
         .PAGE_BITS (PAGE_BITS),
         .SLOT_W    (SLOT_W),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .frame_cnt (frame_cnt),
         .ctl       (ctl),
         .wr_slot   (slot),
         .wr_page   (page_ff),
         .srch_i    (srch[i]),
         .page_i    (tok_page[i]),
         .srch_o    (srch[i+1]),
         .page_o    (tok_page[i+1])
      );
      assign tok_vec[i] = srch[i+1].valid;
   end

   `FPRC_ASSERT_IMPL(a_token_return, launch, ##FRAMES srch[FRAMES].valid)
   `FPRC_ASSERT_IMPL(a_single_token, 1'b1, $onehot0(tok_vec))
   `FPRC_ASSERT_NEXT(a_commit_shows, commit, rsp_chan.valid)
   `FPRC_ASSERT_IMPL(a_idle_no_token, state_ff == fprc_pkg::ST_IDLE, tok_vec == '0)

endmodule

@@ rtl/fprc_cell.sv @@
// Cell: one frame slot with its share of the lookup chain
module fprc_cell #(
   parameter int INDEX     = 0,
   parameter int PAGE_BITS = fprc_pkg::PAGE_BITS_DEFAULT,
   parameter int SLOT_W    = 4,
   parameter int CNT_W     = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [CNT_W-1:0]          frame_cnt,
   input  fprc_pkg::cell_ctl_type    ctl,
   input  logic [SLOT_W-1:0]         wr_slot,
   input  logic [PAGE_BITS-1:0]      wr_page,
   input  fprc_pkg::search_type      srch_i,
   input  logic [PAGE_BITS-1:0]      page_i,
   output fprc_pkg::search_type      srch_o,
   output logic [PAGE_BITS-1:0]      page_o
);

   logic [PAGE_BITS-1:0]  frame_page_ff;
   logic                  frame_valid_ff;
   logic                  frame_valid_in;
   fprc_pkg::search_type  srch_ff;
   fprc_pkg::search_type  srch_in;
   logic [PAGE_BITS-1:0]  tok_page_ff;
   logic                  active;
   logic                  sel;

   assign active = CNT_W'(INDEX) < frame_cnt;
   assign sel    = ctl.write_en && (wr_slot == SLOT_W'(INDEX));

   always_comb begin
      srch_in.valid = srch_i.valid;
      srch_in.hit   = srch_i.hit || (active && frame_valid_ff && (frame_page_ff == page_i));
   end

   always_comb begin
      frame_valid_in = frame_valid_ff;
      if (ctl.clear) begin
         frame_valid_in = 1'b0;
      end else if (sel) begin
         frame_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         srch_ff.valid  <= 1'b0;
      end else begin
         frame_valid_ff <= frame_valid_in;
         srch_ff        <= srch_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_page_ff <= page_i;
      if (sel) begin
         frame_page_ff <= wr_page;
      end
   end

   assign srch_o = srch_ff;
   assign page_o = tok_page_ff;

endmodule
